[hw/rtl/isotropic_damage_stress_update_macros.svh]
// assertion macros for the damage stress update block
`ifndef ISOTROPIC_DAMAGE_STRESS_UPDATE_MACROS_SVH
`define ISOTROPIC_DAMAGE_STRESS_UPDATE_MACROS_SVH

// same-cycle implication
`define IDSU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("idsu assertion failed");

// next-cycle implication
`define IDSU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("idsu assertion failed");

`endif

[hw/rtl/idsu_pkg.sv]
// types and constants shared by the damage stress update block
package idsu_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned DMG_W  = 17;
   localparam int unsigned SIG_W  = 40;
   localparam int unsigned IDX_W  = 8;
   localparam int unsigned QUO_W  = 16;
   localparam int unsigned REM_W  = 32;
   localparam int unsigned PAR_W  = 31;

   localparam logic [DMG_W-1:0] ONE_Q16 = 17'd65536;

   localparam logic [IDX_W-1:0] REG_LAMBDA    = 8'd0;
   localparam logic [IDX_W-1:0] REG_SHEAR     = 8'd1;
   localparam logic [IDX_W-1:0] REG_THRESHOLD = 8'd2;
   localparam logic [IDX_W-1:0] REG_SOFTENING = 8'd3;

   typedef struct packed {
      logic signed [WORD_W-1:0] strain_xx;
      logic signed [WORD_W-1:0] strain_xy;
      logic signed [WORD_W-1:0] strain_xz;
      logic signed [WORD_W-1:0] strain_yx;
      logic signed [WORD_W-1:0] strain_yy;
      logic signed [WORD_W-1:0] strain_yz;
      logic signed [WORD_W-1:0] strain_zx;
      logic signed [WORD_W-1:0] strain_zy;
      logic signed [WORD_W-1:0] strain_zz;
      logic [DMG_W-1:0]         damage_in;
   } req_word_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] stress_xx;
      logic signed [WORD_W-1:0] stress_yy;
      logic signed [WORD_W-1:0] stress_zz;
      logic signed [WORD_W-1:0] stress_xy;
      logic signed [WORD_W-1:0] stress_xz;
      logic signed [WORD_W-1:0] stress_yz;
      logic [DMG_W-1:0]         damage_out;
   } rsp_word_type;

   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [WORD_W-1:0] value;
   } csr_word_type;

   // stresses and damage decision carried alongside the divider
   typedef struct packed {
      logic [5:0][SIG_W-1:0] sig;
      logic [DMG_W-1:0]      dmg;
      logic                  grow;
      logic                  big;
   } side_type;

   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

endpackage

[hw/rtl/idsu_ifs.sv]
// handshake channel interfaces of the damage stress update block
interface idsu_req_if;
   import idsu_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface idsu_rsp_if;
   import idsu_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface idsu_csr_if;
   import idsu_pkg::*;
   logic         valid;
   logic         ready;
   csr_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/idsu_div.sv]
// pipelined restoring divider, one quotient bit per stage, sideband carried along
module idsu_div (
   input  logic                        clock,
   input  logic                        reset,
   input  idsu_pkg::pipe_ctl_type      ctl,
   input  logic [idsu_pkg::PAR_W-1:0]  divisor,
   input  logic [idsu_pkg::PAR_W-1:0]  rem_start,
   input  idsu_pkg::side_type          side_start,
   output logic                        out_valid,
   output logic [idsu_pkg::QUO_W-1:0]  out_quo,
   output idsu_pkg::side_type          out_side
);
   import idsu_pkg::*;

   logic [QUO_W-1:0]             vld_ff;
   logic [QUO_W-1:0][REM_W-1:0]  rem_ff;
   logic [QUO_W-1:0][QUO_W-1:0]  quo_ff;
   side_type [QUO_W-1:0]         side_ff;

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [REM_W-1:0] rem_prev;
      logic [QUO_W-1:0] quo_prev;
      side_type         side_prev;
      logic             vld_prev;
      logic [REM_W-1:0] twice;
      logic             fits;
      logic [REM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_prev  = {1'b0, rem_start};
         assign quo_prev  = '0;
         assign side_prev = side_start;
         assign vld_prev  = ctl.valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      always_comb begin
         twice  = {rem_prev[REM_W-2:0], 1'b0};
         fits   = twice >= {1'b0, divisor};
         rem_in = fits ? twice - {1'b0, divisor} : twice;
         quo_in = {quo_prev[QUO_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (ctl.advance) begin
            vld_ff[k] <= vld_prev;
         end
         if (ctl.advance) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

[hw/rtl/isotropic_damage_stress_update.sv]
// top level: elastic stress, energy, damage growth and damaged stress pipeline
//
//  channel | dir | payload
//  req     | in  | nine strain elements Q16.16, damage Q1.16
//  rsp     | out | six damaged stresses Q16.16, new damage Q1.16
//  csr     | in  | register index, 32-bit value, always ready
//
// one word per cycle while no finished rsp word is waiting
// pipeline: the 16-stage quotient divider plus 7 arithmetic stages
// synchronous reset clears valid bits and loads register defaults
// the whole pipeline holds while a finished rsp word waits; nothing is dropped
`include "isotropic_damage_stress_update_macros.svh"

module isotropic_damage_stress_update (
   input logic clock,
   input logic reset,
   idsu_req_if.sink   req_port,
   idsu_rsp_if.source rsp_port,
   idsu_csr_if.sink   csr_port
);
   import idsu_pkg::*;

   localparam logic signed [50:0] SIG_HI = 51'sd549755813887;
   localparam logic signed [50:0] SIG_LO = -51'sd549755813888;
   localparam logic signed [41:0] OUT_HI = 42'sd2147483647;
   localparam logic signed [41:0] OUT_LO = -42'sd2147483648;
   // stress slot for each strain element, row-major
   localparam logic [2:0] EMAP [9] = '{3'd0, 3'd3, 3'd4, 3'd3, 3'd1, 3'd5, 3'd4, 3'd5, 3'd2};

   function automatic logic [SIG_W-1:0] sat_sig(input logic signed [50:0] v);
      logic [SIG_W-1:0] r;
      if (v > SIG_HI) r = SIG_HI[SIG_W-1:0];
      else if (v < SIG_LO) r = SIG_LO[SIG_W-1:0];
      else r = v[SIG_W-1:0];
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] sat_out(input logic signed [41:0] v);
      logic [WORD_W-1:0] r;
      if (v > OUT_HI) r = OUT_HI[WORD_W-1:0];
      else if (v < OUT_LO) r = OUT_LO[WORD_W-1:0];
      else r = v[WORD_W-1:0];
      return r;
   endfunction

   // registers
   logic signed [WORD_W-1:0] lambda_ff;
   logic signed [WORD_W-1:0] shear_ff;
   logic [PAR_W-1:0]         yd_ff;
   logic [PAR_W-1:0]         sd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_ff <= '0;
         shear_ff  <= '0;
         yd_ff     <= '0;
         sd_ff     <= PAR_W'(ONE_Q16);
      end else if (csr_port.valid && csr_port.ready) begin
         unique case (csr_port.data.index)
            REG_LAMBDA:    lambda_ff <= csr_port.data.value;
            REG_SHEAR:     shear_ff  <= csr_port.data.value;
            REG_THRESHOLD: yd_ff     <= csr_port.data.value[PAR_W-1:0];
            REG_SOFTENING: sd_ff     <= csr_port.data.value[PAR_W-1:0];
            default: ;
         endcase
      end
   end
   assign csr_port.ready = 1'b1;

   logic advance;
   logic rsp_valid_ff;
   assign advance = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = advance;

   // stage 1: lambda*trace and mu products
   logic signed [WORD_W-1:0] e_c [9];
   logic signed [33:0]       tr_c;
   logic signed [65:0]       lt_p;
   logic signed [64:0]       mu_p [6];
   logic signed [32:0]       mu_arg [6];

   logic                     v1_ff;
   logic signed [WORD_W-1:0] e1_ff [9];
   logic [DMG_W-1:0]         d1_ff;
   logic signed [49:0]       lt1_ff;
   logic signed [48:0]       mu1_ff [6];

   always_comb begin
      e_c[0] = req_port.data.strain_xx;
      e_c[1] = req_port.data.strain_xy;
      e_c[2] = req_port.data.strain_xz;
      e_c[3] = req_port.data.strain_yx;
      e_c[4] = req_port.data.strain_yy;
      e_c[5] = req_port.data.strain_yz;
      e_c[6] = req_port.data.strain_zx;
      e_c[7] = req_port.data.strain_zy;
      e_c[8] = req_port.data.strain_zz;
      tr_c = 34'(e_c[0]) + 34'(e_c[4]) + 34'(e_c[8]);
      lt_p = 66'(lambda_ff) * 66'(tr_c);
      mu_arg[0] = 33'(e_c[0]) <<< 1;
      mu_arg[1] = 33'(e_c[4]) <<< 1;
      mu_arg[2] = 33'(e_c[8]) <<< 1;
      mu_arg[3] = 33'(e_c[1]) + 33'(e_c[3]);
      mu_arg[4] = 33'(e_c[2]) + 33'(e_c[6]);
      mu_arg[5] = 33'(e_c[5]) + 33'(e_c[7]);
      for (int i = 0; i < 6; i++) begin
         mu_p[i] = 65'(shear_ff) * 65'(mu_arg[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_port.valid;
      end
      if (advance) begin
         e1_ff  <= e_c;
         d1_ff  <= req_port.data.damage_in;
         lt1_ff <= lt_p[65:16];
         for (int i = 0; i < 6; i++) begin
            mu1_ff[i] <= mu_p[i][64:16];
         end
      end
   end

   // stage 2: undamaged stresses, saturated to 40 bits
   logic [SIG_W-1:0] s_c [6];
   logic                     v2_ff;
   logic signed [WORD_W-1:0] e2_ff [9];
   logic [DMG_W-1:0]         d2_ff;
   logic [SIG_W-1:0]         s2_ff [6];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s_c[i] = sat_sig(51'(lt1_ff) + 51'(mu1_ff[i]));
      end
      for (int i = 3; i < 6; i++) begin
         s_c[i] = sat_sig(51'(mu1_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         e2_ff <= e1_ff;
         d2_ff <= d1_ff;
         s2_ff <= s_c;
      end
   end

   // stage 3: energy terms
   logic signed [71:0] ey_p [9];
   logic               v3_ff;
   logic signed [55:0] ey3_ff [9];
   side_type           side3_ff;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         ey_p[i] = 72'(e2_ff[i]) * 72'($signed(s2_ff[EMAP[i]]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
      if (advance) begin
         for (int i = 0; i < 9; i++) begin
            ey3_ff[i] <= ey_p[i][71:16];
         end
         for (int i = 0; i < 6; i++) begin
            side3_ff.sig[i] <= s2_ff[i];
         end
         side3_ff.dmg  <= d2_ff;
         side3_ff.grow <= 1'b0;
         side3_ff.big  <= 1'b0;
      end
   end

   // stage 4: energy sum, halved; growth bound Sd*d
   logic signed [59:0] ysum_c;
   logic [47:0]        sdd_p;
   logic               v4_ff;
   logic signed [59:0] y4_ff;
   logic [31:0]        sdd4_ff;
   side_type           side4_ff;

   always_comb begin
      ysum_c = '0;
      for (int i = 0; i < 9; i++) begin
         ysum_c = ysum_c + 60'(ey3_ff[i]);
      end
      sdd_p = 48'(sd_ff) * 48'(side3_ff.dmg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
      if (advance) begin
         y4_ff    <= ysum_c >>> 1;
         sdd4_ff  <= sdd_p[47:16];
         side4_ff <= side3_ff;
      end
   end

   // stage 5: growth decision and divider start
   logic signed [59:0] excess_c;
   logic               grow_c;
   logic               big_c;
   side_type           side5_c;
   logic               v5_ff;
   logic [PAR_W-1:0]   rem5_ff;
   side_type           side5_ff;

   always_comb begin
      excess_c = y4_ff - $signed({29'd0, yd_ff});
      grow_c   = excess_c > $signed({28'd0, sdd4_ff});
      big_c    = excess_c >= $signed({29'd0, sd_ff});
      side5_c      = side4_ff;
      side5_c.grow = grow_c;
      side5_c.big  = big_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= v4_ff;
      end
      if (advance) begin
         rem5_ff  <= excess_c[PAR_W-1:0];
         side5_ff <= side5_c;
      end
   end

   // quotient floor(excess*65536/Sd), meaningful when excess < Sd
   pipe_ctl_type     div_ctl;
   logic             div_valid;
   logic [QUO_W-1:0] div_quo;
   side_type         div_side;

   assign div_ctl.advance = advance;
   assign div_ctl.valid   = v5_ff;

   idsu_div u_div (
      .clock      (clock),
      .reset      (reset),
      .ctl        (div_ctl),
      .divisor    (sd_ff),
      .rem_start  (rem5_ff),
      .side_start (side5_ff),
      .out_valid  (div_valid),
      .out_quo    (div_quo),
      .out_side   (div_side)
   );

   // stage f1: final damage and damaged stress products
   logic [DMG_W-1:0]   dsel_c;
   logic [DMG_W-1:0]   dcap_c;
   logic [DMG_W-1:0]   keep_c;
   logic signed [57:0] dp_c [6];
   logic               vf_ff;
   logic signed [41:0] dp_ff [6];
   logic [DMG_W-1:0]   df_ff;

   always_comb begin
      if (div_side.grow) begin
         dsel_c = div_side.big ? ONE_Q16 : {1'b0, div_quo};
      end else begin
         dsel_c = div_side.dmg;
      end
      dcap_c = (dsel_c > ONE_Q16) ? ONE_Q16 : dsel_c;
      keep_c = ONE_Q16 - dcap_c;
      for (int i = 0; i < 6; i++) begin
         dp_c[i] = 58'($signed(div_side.sig[i])) * 58'($signed({1'b0, keep_c}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else if (advance) begin
         vf_ff <= div_valid;
      end
      if (advance) begin
         for (int i = 0; i < 6; i++) begin
            dp_ff[i] <= dp_c[i][57:16];
         end
         df_ff <= dcap_c;
      end
   end

   // output register
   rsp_word_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vf_ff;
      end
      if (advance) begin
         rsp_ff.stress_xx  <= sat_out(dp_ff[0]);
         rsp_ff.stress_yy  <= sat_out(dp_ff[1]);
         rsp_ff.stress_zz  <= sat_out(dp_ff[2]);
         rsp_ff.stress_xy  <= sat_out(dp_ff[3]);
         rsp_ff.stress_xz  <= sat_out(dp_ff[4]);
         rsp_ff.stress_yz  <= sat_out(dp_ff[5]);
         rsp_ff.damage_out <= df_ff;
      end
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.data  = rsp_ff;

   `IDSU_ASSERT_NOW(a_damage_capped, clock, reset, rsp_valid_ff, rsp_ff.damage_out <= ONE_Q16)
   `IDSU_ASSERT_NOW(a_full_damage_zero, clock, reset, rsp_valid_ff && rsp_ff.damage_out == ONE_Q16, rsp_ff.stress_xx == '0 && rsp_ff.stress_yy == '0 && rsp_ff.stress_zz == '0 && rsp_ff.stress_xy == '0 && rsp_ff.stress_xz == '0 && rsp_ff.stress_yz == '0)
   `IDSU_ASSERT_NEXT(a_lambda_write, clock, reset, csr_port.valid && csr_port.ready && csr_port.data.index == REG_LAMBDA, lambda_ff == $signed($past(csr_port.data.value)))

endmodule

[bench/idsu_tb_ifs.sv]
// bench constants shared by the testbench
package idsu_tb_consts;
   localparam int unsigned TB_LATENCY = 23;
endpackage

[bench/isotropic_damage_stress_update_tb.sv]
// self-checking bench for the damage stress update block: predicted stresses and damage per word
module isotropic_damage_stress_update_tb;
   import idsu_pkg::*;
   import idsu_tb_consts::*;

   localparam longint SIG_HI = 64'sd549755813887;
   localparam longint SIG_LO = -64'sd549755813888;

   logic clock = 1'b0;
   logic reset = 1'b1;

   idsu_req_if req_ch ();
   idsu_rsp_if rsp_ch ();
   idsu_csr_if csr_ch ();

   isotropic_damage_stress_update u_dut (
      .clock(clock),
      .reset(reset),
      .req_port(req_ch.sink),
      .rsp_port(rsp_ch.source),
      .csr_port(csr_ch.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the registers
   longint lambda_q, mu_q, yd_q, sd_q;

   req_word_type strain_queue[$];
   rsp_word_type stress_queue[$];
   int send_idle_pct, recv_idle_pct;
   int mismatches, words_sent, words_checked, grown_count, full_count;
   bit sender_hold;

   // exact floor(a*b/2^16) via split of b
   function automatic longint qmul(longint a, longint b);
      longint hi, lo;
      hi = b >>> 16;
      lo = b - hi * 65536;
      return a * hi + ((a * lo) >>> 16);
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic [31:0] scale_stress(longint s, longint keep);
      longint prod, hi, lo;
      hi = s >>> 16;
      lo = s - hi * 65536;
      prod = hi * keep + ((lo * keep) >>> 16);
      return 32'(clamp(prod, -64'sd2147483648, 64'sd2147483647));
   endfunction

   function automatic rsp_word_type predict_stress(req_word_type w);
      longint e[9];
      longint s[9];
      longint tr, y, excess, d, keep;
      rsp_word_type r;
      e[0] = longint'(w.strain_xx); e[1] = longint'(w.strain_xy);
      e[2] = longint'(w.strain_xz); e[3] = longint'(w.strain_yx);
      e[4] = longint'(w.strain_yy); e[5] = longint'(w.strain_yz);
      e[6] = longint'(w.strain_zx); e[7] = longint'(w.strain_zy);
      e[8] = longint'(w.strain_zz);
      d = longint'({1'b0, w.damage_in});
      tr = e[0] + e[4] + e[8];
      s[0] = clamp(qmul(lambda_q, tr) + qmul(mu_q, 2 * e[0]), SIG_LO, SIG_HI);
      s[4] = clamp(qmul(lambda_q, tr) + qmul(mu_q, 2 * e[4]), SIG_LO, SIG_HI);
      s[8] = clamp(qmul(lambda_q, tr) + qmul(mu_q, 2 * e[8]), SIG_LO, SIG_HI);
      s[1] = clamp(qmul(mu_q, e[1] + e[3]), SIG_LO, SIG_HI);
      s[3] = s[1];
      s[2] = clamp(qmul(mu_q, e[2] + e[6]), SIG_LO, SIG_HI);
      s[6] = s[2];
      s[5] = clamp(qmul(mu_q, e[5] + e[7]), SIG_LO, SIG_HI);
      s[7] = s[5];
      y = 0;
      for (int i = 0; i < 9; i++) y += qmul(e[i], s[i]);
      y = y >>> 1;
      excess = y - yd_q;
      if (excess > ((sd_q * d) >>> 16)) begin
         grown_count++;
         if (excess >= sd_q) d = 65536;
         else d = (excess * 65536) / sd_q;
      end
      if (d > 65536) d = 65536;
      if (d == 65536) full_count++;
      keep = 65536 - d;
      r.stress_xx = scale_stress(s[0], keep);
      r.stress_yy = scale_stress(s[4], keep);
      r.stress_zz = scale_stress(s[8], keep);
      r.stress_xy = scale_stress(s[1], keep);
      r.stress_xz = scale_stress(s[2], keep);
      r.stress_yz = scale_stress(s[5], keep);
      r.damage_out = d[DMG_W-1:0];
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            stress_queue.push_back(predict_stress(req_ch.data));
            words_sent++;
         end
         if (strain_queue.size() != 0 && !sender_hold
               && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.data <= strain_queue.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (stress_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected rsp word %h", rsp_ch.data);
            end else begin
               rsp_word_type want;
               want = stress_queue.pop_front();
               words_checked++;
               if (rsp_ch.data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch word %0d: exp %h got %h",
                        words_checked, want, rsp_ch.data);
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(-$signed(32'($urandom_range(200000))));
         3, 4: return 32'($urandom_range(200000));
         5: return 32'(32'sd65536 * $signed(32'($urandom_range(8))) - 32'sd262144);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [16:0] pick_damage();
      case ($urandom_range(5))
         0: return 17'd0;
         1: return ONE_Q16;
         2: return 17'($urandom_range(131071));
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   function automatic req_word_type random_strain();
      req_word_type w;
      w.strain_xx = pick_word(); w.strain_xy = pick_word(); w.strain_xz = pick_word();
      w.strain_yx = pick_word(); w.strain_yy = pick_word(); w.strain_yz = pick_word();
      w.strain_zx = pick_word(); w.strain_zy = pick_word(); w.strain_zz = pick_word();
      w.damage_in = pick_damage();
      return w;
   endfunction

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= '{index: idx, value: val};
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         REG_LAMBDA: lambda_q = longint'($signed(val));
         REG_SHEAR: mu_q = longint'($signed(val));
         REG_THRESHOLD: yd_q = longint'(val[30:0]);
         REG_SOFTENING: sd_q = longint'(val[30:0]);
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      while (strain_queue.size() != 0 || req_ch.valid || stress_queue.size() != 0)
         @(posedge clock);
      repeat (TB_LATENCY + 5) @(posedge clock);
   endtask

   task automatic run_phase(int n, logic [31:0] lam, logic [31:0] mu,
         logic [31:0] yd, logic [31:0] sd);
      write_reg(REG_LAMBDA, lam);
      write_reg(REG_SHEAR, mu);
      write_reg(REG_THRESHOLD, yd);
      write_reg(REG_SOFTENING, sd);
      for (int i = 0; i < n; i++) strain_queue.push_back(random_strain());
      drain();
   endtask

   initial begin
      req_word_type w;
      int sent_mark;
      lambda_q = 0; mu_q = 0; yd_q = 0; sd_q = 65536;
      req_ch.valid = 1'b0; req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0; csr_ch.data = '0;
      send_idle_pct = 29; recv_idle_pct = 62;
      sender_hold = 1'b0;
      mismatches = 0; words_sent = 0; words_checked = 0;
      grown_count = 0; full_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset constants, then extremes and special cases
      strain_queue.push_back(random_strain());
      drain();
      write_reg(REG_LAMBDA, 32'h0001_8000);
      write_reg(REG_SHEAR, 32'h0001_0000);
      write_reg(REG_THRESHOLD, 32'h0000_4000);
      write_reg(REG_SOFTENING, 32'h0002_0000);
      write_reg(8'd9, 32'hdead_beef);       // unknown index, ignored
      w = '0; strain_queue.push_back(w);
      w = '{default: 32'h7fff_ffff}; w.damage_in = 17'd0; strain_queue.push_back(w);
      w = '{default: 32'h8000_0000}; w.damage_in = ONE_Q16; strain_queue.push_back(w);
      w = '{default: 32'h0000_1000}; w.damage_in = 17'h1ffff; strain_queue.push_back(w);
      w = '{default: 32'h0000_0100}; w.damage_in = 17'd100; strain_queue.push_back(w);
      w = '{default: 32'h0000_8000}; w.damage_in = 17'd0; strain_queue.push_back(w);
      w = '{default: 32'hffff_0000}; w.damage_in = 17'd30000; strain_queue.push_back(w);
      w = '{default: 32'h0000_0800}; w.damage_in = 17'd65535; strain_queue.push_back(w);
      drain();
      write_reg(REG_SOFTENING, 32'h0000_0000);  // zero softening
      w = '{default: 32'h0001_0000}; w.damage_in = 17'd5; strain_queue.push_back(w);
      w = '0; w.damage_in = 17'd7; strain_queue.push_back(w);
      drain();

      run_phase(250, 32'h0000_8000, 32'h0000_4000, 32'h0000_0100, 32'h0001_0000);
      // sender holds mid-stream until all results are back
      sent_mark = words_sent;
      for (int i = 0; i < 20; i++) strain_queue.push_back(random_strain());
      while (words_sent < sent_mark + 8) @(posedge clock);
      sender_hold = 1'b1;
      while (stress_queue.size() != 0 || req_ch.valid) @(posedge clock);
      sender_hold = 1'b0;
      drain();
      send_idle_pct = 62; recv_idle_pct = 29;
      run_phase(250, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      run_phase(100, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001);
      send_idle_pct = 0; recv_idle_pct = 0;
      run_phase(200, $urandom, $urandom, $urandom_range(300000), $urandom_range(1, 400000));
      run_phase(200, 32'h0000_2000, 32'h0000_1000, 32'h0000_0000, 32'h0000_8000);

      $display("checked %0d of %0d words; damage grew in %0d, full damage in %0d",
         words_checked, words_sent, grown_count, full_count);
      $display("phases covered idle sender, stalled receiver, full rate and extreme constants");
      if (mismatches == 0 && stress_queue.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/idsu_pkg.sv
hw/rtl/idsu_ifs.sv
hw/rtl/idsu_div.sv
hw/rtl/isotropic_damage_stress_update.sv
bench/idsu_tb_ifs.sv
bench/isotropic_damage_stress_update_tb.sv
